FILE: sv/bsfd_pkg.sv
// Shared types, constants and the CRC-16-CCITT byte step for the frame decoder.
// No dependencies.
package bsfd_pkg;

    // Buffer sizing default
    localparam int BUFFER_DEPTH_DEF = 64;

    // Config port sizing
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LIMIT_W    = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [7:0]         START_RST  = 8'd126;
    localparam logic [7:0]         STOP_RST   = 8'd127;
    localparam logic [7:0]         ESCAPE_RST = 8'd125;
    localparam logic               CRC_EN_RST = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 7'd0;

    // Outcome codes
    localparam logic [1:0] OC_GOOD   = 2'd0;
    localparam logic [1:0] OC_SHORT  = 2'd1;
    localparam logic [1:0] OC_BADCRC = 2'd2;
    localparam logic [1:0] OC_LARGE  = 2'd3;

    // CRC and stuffing constants
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  ESCAPE_XOR = 8'h20;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,   // taking link bytes
        ST_READ = 3'b010,   // issue buffer read for next payload byte
        ST_SEND = 3'b100    // read data ready, load output word
    } state_t;

    // One byte through CRC-16-CCITT, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: sv/bsfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: sv/byte_stuffed_frame_decoder_crc16_top.sv
// Top level of the byte-stuffed frame decoder with CRC-16-CCITT check.
// Depends on bsfd_pkg and bsfd_ram.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_byte                | input word
//  out     | out_valid, out_ready, out_byte, byte_valid,| result word
//          | outcome, last                              |
//  cfg     | cfg_we, cfg_index, cfg_data                | register write
//
// Link bytes are taken one per cycle while a frame fills; the CRC runs two
// bytes behind the buffer write so it is ready when the stop byte arrives.
// A good frame of n payload bytes is read back from the buffer RAM byte by
// byte (read, then load), held while out_ready stalls; no input meanwhile.
// A status or empty-frame word goes straight to the output register; input
// then waits only while that word is held. Reset needs no clearing pass.
module byte_stuffed_frame_decoder_crc16_top
    import bsfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic [1:0]            outcome,
    output logic                  last,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    // Config registers
    logic [7:0]         start_code_reg, stop_code_reg, escape_code_reg;
    logic               crc_enable_reg;
    logic [LIMIT_W-1:0] frame_limit_reg;

    // Frame state
    state_t             state_reg, state_next;
    logic               inside_reg, inside_next;
    logic               esc_reg, esc_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         prev1_reg, prev1_next;   // newest stored byte
    logic [7:0]         prev2_reg, prev2_next;   // byte before that
    logic [CNT_W-1:0]   emit_len_reg, emit_len_next;
    logic [CNT_W-1:0]   emit_idx_reg, emit_idx_next;

    // Output word register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               byte_valid_reg, byte_valid_next;
    logic [1:0]         outcome_reg, outcome_next;
    logic               last_reg, last_next;

    // Buffer RAM ports
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [7:0]         ram_wdata, ram_rdata;

    logic               out_free, in_take;
    logic [CNT_W-1:0]   limit;
    logic [7:0]         data_byte;

    bsfd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Config writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_RST;
            stop_code_reg   <= STOP_RST;
            escape_code_reg <= ESCAPE_RST;
            crc_enable_reg  <= CRC_EN_RST;
            frame_limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:  start_code_reg  <= cfg_data[7:0];
                REG_STOP:   stop_code_reg   <= cfg_data[7:0];
                REG_ESCAPE: escape_code_reg <= cfg_data[7:0];
                REG_CRC_EN: crc_enable_reg  <= cfg_data[0];
                REG_LIMIT:  frame_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Active frame limit: nonzero limit up to the depth, else the depth
    always_comb
    begin
        if (frame_limit_reg != '0 && frame_limit_reg <= LIMIT_W'(BUFFER_DEPTH))
            limit = CNT_W'(frame_limit_reg);
        else
            limit = CNT_W'(BUFFER_DEPTH);
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_RUN) && out_free;
    assign in_take   = in_valid && in_ready;
    assign data_byte = esc_reg ? (in_byte ^ ESCAPE_XOR) : in_byte;

    // Deframing, close-out and read-back sequencing
    always_comb
    begin
        state_next      = state_reg;
        inside_next     = inside_reg;
        esc_next        = esc_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        prev1_next      = prev1_reg;
        prev2_next      = prev2_reg;
        emit_len_next   = emit_len_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        outcome_next    = outcome_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[ADDR_W-1:0];
        ram_wdata       = data_byte;
        ram_re          = 1'b0;
        ram_raddr       = emit_idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_RUN:
            begin
                if (in_take)
                begin
                    if (in_byte == start_code_reg)
                    begin
                        inside_next = 1'b1;
                        esc_next    = 1'b0;
                        fill_next   = '0;
                        crc_next    = CRC_INIT;
                    end
                    else if (inside_reg && in_byte == stop_code_reg)
                    begin
                        // close the frame; every branch leaves it
                        inside_next     = 1'b0;
                        esc_next        = 1'b0;
                        fill_next       = '0;
                        out_byte_next   = 8'h00;
                        byte_valid_next = 1'b0;
                        last_next       = 1'b1;
                        if (crc_enable_reg && fill_reg < CNT_W'(2))
                        begin
                            out_valid_next = 1'b1;
                            outcome_next   = OC_SHORT;
                        end
                        else if (crc_enable_reg && crc_reg != {prev2_reg, prev1_reg})
                        begin
                            out_valid_next = 1'b1;
                            outcome_next   = OC_BADCRC;
                        end
                        else
                        begin
                            emit_len_next = crc_enable_reg ? fill_reg - CNT_W'(2)
                                                           : fill_reg;
                            emit_idx_next = '0;
                            if (emit_len_next == '0)
                            begin
                                out_valid_next = 1'b1;
                                outcome_next   = OC_GOOD;
                            end
                            else
                                state_next = ST_READ;
                        end
                    end
                    else if (inside_reg && !esc_reg && in_byte == escape_code_reg)
                        esc_next = 1'b1;
                    else if (inside_reg)
                    begin
                        esc_next = 1'b0;
                        if (fill_reg >= limit)
                        begin
                            inside_next     = 1'b0;
                            fill_next       = '0;
                            out_valid_next  = 1'b1;
                            out_byte_next   = 8'h00;
                            byte_valid_next = 1'b0;
                            outcome_next    = OC_LARGE;
                            last_next       = 1'b1;
                        end
                        else
                        begin
                            // store, and fold the byte two behind into the CRC
                            ram_we     = 1'b1;
                            fill_next  = fill_reg + CNT_W'(1);
                            prev1_next = data_byte;
                            prev2_next = prev1_reg;
                            if (fill_reg >= CNT_W'(2))
                                crc_next = crc16_byte(crc_reg, prev2_reg);
                        end
                    end
                end
            end

            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_SEND;
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = ram_rdata;
                    byte_valid_next = 1'b1;
                    outcome_next    = OC_GOOD;
                    last_next       = (emit_idx_reg + CNT_W'(1) == emit_len_reg);
                    emit_idx_next   = emit_idx_reg + CNT_W'(1);
                    state_next      = last_next ? ST_RUN : ST_READ;
                end
            end

            default:
                state_next = ST_RUN;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            inside_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            fill_reg      <= '0;
            emit_len_reg  <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inside_reg    <= inside_next;
            esc_reg       <= esc_next;
            fill_reg      <= fill_next;
            emit_len_reg  <= emit_len_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        crc_reg        <= crc_next;
        prev1_reg      <= prev1_next;
        prev2_reg      <= prev2_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        outcome_reg    <= outcome_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign outcome    = outcome_reg;
    assign last       = last_reg;

endmodule
